[hw/rtl/interrupt_vector_allocator_unit_macros.svh]
// Assertion macros for the interrupt vector allocator.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef INTERRUPT_VECTOR_ALLOCATOR_UNIT_MACROS_SVH
`define INTERRUPT_VECTOR_ALLOCATOR_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent
`define IVAU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent
`define IVAU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/ivau_pkg.sv]
// Shared types and constants for the interrupt vector allocator.
// No dependencies.
package ivau_pkg;

    // Request codes
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Map layout and fixed vector numbers
    localparam int unsigned WORD_BITS   = 32;
    localparam int unsigned FIRST_ALLOC = 48;
    localparam int unsigned FIELD_LIMIT = 256;
    localparam int unsigned RSV_LOW     = 32;
    localparam int unsigned RSV_VEC_A   = 32'h21;
    localparam int unsigned RSV_VEC_B   = 32'h40;

    typedef struct packed {
        logic       req_type;
        logic [7:0] vector_number;
    } req_item_t;

    typedef struct packed {
        logic [7:0] granted_vector;
        logic       success;
    } rsp_item_t;

    // Contents of a map word after reset: low vectors and two fixed ones in use
    function automatic logic [WORD_BITS-1:0] reset_word(input int unsigned w);
        logic [WORD_BITS-1:0] word;
        int unsigned          v;
        word = '0;
        for (int b = 0; b < WORD_BITS; b++)
        begin
            v = w * WORD_BITS + b;
            word[b] = (v < RSV_LOW) || (v == RSV_VEC_A) || (v == RSV_VEC_B);
        end
        return word;
    endfunction

endpackage

[hw/rtl/ivau_stream_if.sv]
// Valid/ready channel carrying one item per handshake.
// Payload type is set by the instantiating level (see ivau_pkg).
interface ivau_stream_if #(parameter type item_t = logic);
    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/interrupt_vector_allocator_unit.sv]
// Interrupt vector allocator: one request item in, one response item out.
// A free request checks the map word that holds its vector; an allocate request
// scans 32-vector map words from vector 48 upward, one word per cycle from the
// single map memory read port, until it finds a free vector or ends the last word.
// One request is in flight at a time, and it completes only when the output register
// is empty or being read; a new one is accepted while the previous response still waits there.
// The map needs no clearing pass: per-word valid flops make unwritten words read
// as their reset contents, so the block is ready right after reset.
`include "interrupt_vector_allocator_unit_macros.svh"

module interrupt_vector_allocator_unit #(
    parameter int NUM_VECTORS = 256
) (
    input  logic          clk,
    input  logic          rst_n,
    ivau_stream_if.sink   req,
    ivau_stream_if.source rsp
);

    localparam int WB         = ivau_pkg::WORD_BITS;
    localparam int MAP_WORDS  = (NUM_VECTORS + WB - 1) / WB;
    localparam int WORD_AW    = $clog2(MAP_WORDS);
    localparam int SCAN_LIMIT = (NUM_VECTORS < ivau_pkg::FIELD_LIMIT) ?
                                NUM_VECTORS : ivau_pkg::FIELD_LIMIT;
    localparam int START_W    = ivau_pkg::FIRST_ALLOC / WB;
    localparam int LAST_W     = (SCAN_LIMIT - 1) / WB;

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_CHECK = 1'b1;

    logic                 state_reg, state_next;
    logic [WORD_AW-1:0]   cur_word_reg, cur_word_next;
    logic                 req_type_reg;
    logic [7:0]           vec_reg;
    logic                 out_vld_reg;
    ivau_pkg::rsp_item_t  out_data_reg;

    // Map memory and per-word written flags
    logic [WB-1:0]        mem [MAP_WORDS];
    logic [MAP_WORDS-1:0] wvld_reg;
    logic [WB-1:0]        rdata_reg;
    logic                 rd_vld_reg;

    logic                 accept;
    logic [WORD_AW-1:0]   raddr;
    logic [WB-1:0]        word_eff;
    logic [WB-1:0]        scan_mask;
    logic [WB-1:0]        free_bits;
    logic [WB-1:0]        onehot;
    logic [4:0]           hit_idx;
    logic                 found;
    logic                 is_free;
    logic                 vec_ok;
    logic                 finish;
    logic                 out_busy;
    logic                 out_load;
    logic                 mem_we;
    logic [WB-1:0]        wdata;
    ivau_pkg::rsp_item_t  out_data_next;
    logic [10:0]          vec_wide;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign rsp.valid = out_vld_reg;
    assign rsp.data  = out_data_reg;
    assign out_busy  = out_vld_reg && !rsp.ready;
    assign raddr     = cur_word_next;
    assign vec_wide  = {3'b000, req.data.vector_number};

    // Effective word: unwritten words read as their reset contents
    assign word_eff = rd_vld_reg ? rdata_reg : ivau_pkg::reset_word(32'(cur_word_reg));

    // Bits of the current word that lie inside the allocation range
    always_comb
    begin
        logic [31:0] bit_vec;
        bit_vec = '0;
        for (int i = 0; i < WB; i++)
        begin
            bit_vec = (32'(cur_word_reg) << 5) + 32'(i);
            scan_mask[i] = (bit_vec >= ivau_pkg::FIRST_ALLOC) &&
                           (bit_vec < 32'(SCAN_LIMIT));
        end
    end

    // Lowest free bit: isolate it, then encode
    assign free_bits = ~word_eff & scan_mask;
    assign found     = |free_bits;
    assign onehot    = free_bits & (~free_bits + 32'd1);

    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < WB; i++)
        begin
            for (int k = 0; k < 5; k++)
            begin
                if (((i >> k) & 1) == 1)
                begin
                    hit_idx[k] = hit_idx[k] | onehot[i];
                end
            end
        end
    end

    assign is_free = (req_type_reg == ivau_pkg::REQ_FREE);
    assign vec_ok  = (32'(vec_reg) < NUM_VECTORS);
    assign finish  = is_free || found || (cur_word_reg == WORD_AW'(LAST_W));

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        cur_word_next = cur_word_reg;
        out_load      = 1'b0;
        mem_we        = 1'b0;
        wdata         = word_eff | onehot;
        out_data_next = out_data_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_CHECK;
                    if (req.data.req_type == ivau_pkg::REQ_FREE)
                    begin
                        cur_word_next = WORD_AW'(vec_wide >> 5);
                    end
                    else
                    begin
                        cur_word_next = WORD_AW'(START_W);
                    end
                end
            end
            ST_CHECK:
            begin
                if (!finish)
                begin
                    cur_word_next = cur_word_reg + 1'b1;
                end
                else if (!out_busy)
                begin
                    state_next = ST_IDLE;
                    out_load   = 1'b1;
                    if (is_free)
                    begin
                        mem_we = vec_ok;
                        wdata  = word_eff & ~(32'd1 << vec_reg[4:0]);
                        out_data_next.granted_vector = vec_reg;
                        out_data_next.success        = vec_ok;
                    end
                    else
                    begin
                        mem_we = found;
                        out_data_next.granted_vector =
                            found ? 8'((32'(cur_word_reg) << 5) | 32'(hit_idx)) : 8'd0;
                        out_data_next.success = found;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            out_vld_reg <= 1'b0;
            wvld_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_vld_reg <= 1'b0;
            end
            if (mem_we)
            begin
                wvld_reg[cur_word_reg] <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_word_reg <= cur_word_next;
        rd_vld_reg   <= wvld_reg[raddr];
        if (accept)
        begin
            req_type_reg <= req.data.req_type;
            vec_reg      <= req.data.vector_number;
        end
        if (out_load)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // Map memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[cur_word_reg] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    // Assertions
    `IVAU_ASSERT_NEXT(a_accept_to_check, accept, state_reg == ST_CHECK,
        "accepted item did not start a map access")
    `IVAU_ASSERT_NOW(a_write_when_done, mem_we,
        (state_reg == ST_CHECK) && finish && !out_busy,
        "map written outside the final check step")
    `IVAU_ASSERT_NOW(a_grant_in_range, out_load && !is_free && found,
        (32'(out_data_next.granted_vector) >= ivau_pkg::FIRST_ALLOC),
        "granted vector below the allocation range")
    `IVAU_ASSERT_NEXT(a_result_shown, out_load, out_vld_reg,
        "finished item not presented on the response channel")

endmodule

[verif/tb_interrupt_vector_allocator_unit.sv]
// Self-checking testbench for interrupt_vector_allocator_unit.
// Needs ivau_pkg and ivau_stream_if; requests are predicted against a local
// copy of the vector in-use map and responses are checked in order.
`timescale 1ns / 1ps

module tb_interrupt_vector_allocator_unit;

    localparam int NUM_VECTORS = 256;
    localparam int SCAN_END    = (NUM_VECTORS < ivau_pkg::FIELD_LIMIT) ?
                                 NUM_VECTORS : ivau_pkg::FIELD_LIMIT;
    localparam int MAX_REPORTS = 10;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 300;

    logic clk;
    logic rst_n;

    ivau_stream_if #(.item_t(ivau_pkg::req_item_t)) req_if ();
    ivau_stream_if #(.item_t(ivau_pkg::rsp_item_t)) rsp_if ();

    interrupt_vector_allocator_unit #(
        .NUM_VECTORS(NUM_VECTORS)
    ) u_top (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_if.sink),
        .rsp  (rsp_if.source)
    );

    // Requests waiting to be offered, and responses the map predicts
    ivau_pkg::req_item_t pending_reqs[$];
    ivau_pkg::rsp_item_t expected_grants[$];

    // Local copy of the in-use map, touched only by the driver
    logic [NUM_VECTORS-1:0] vec_in_use;

    int total_reqs;
    int sent_cnt;
    int rcv_cnt;
    int mismatch_cnt;
    int gap_cnt;
    int stall_cnt;
    logic hold_rsp;

    // Clock and reset
    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    initial
    begin
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Apply one request to the local map and return the response it gives
    function automatic ivau_pkg::rsp_item_t predict_grant(input ivau_pkg::req_item_t item);
        ivau_pkg::rsp_item_t r;
        bit                  found;
        r     = '0;
        found = 1'b0;
        if (item.req_type == ivau_pkg::REQ_ALLOC)
        begin
            // Lowest free vector from the first allocatable one upward
            for (int v = ivau_pkg::FIRST_ALLOC; v < SCAN_END; v++)
            begin
                if (!found && !vec_in_use[v])
                begin
                    found            = 1'b1;
                    vec_in_use[v]    = 1'b1;
                    r.granted_vector = 8'(v);
                    r.success        = 1'b1;
                end
            end
        end
        else
        begin
            r.granted_vector = item.vector_number;
            if (int'(item.vector_number) < NUM_VECTORS)
            begin
                vec_in_use[item.vector_number] = 1'b0;
                r.success = 1'b1;
            end
        end
        return r;
    endfunction

    // Idle draw: a random gap length, or none during stretches of back-to-back items
    function automatic int draw_idle(input int count);
        if ((count / 50) % 5 == 4)
            return 0;
        return $urandom_range(0, 9);
    endfunction

    task automatic add_req(input logic kind, input logic [7:0] vec);
        ivau_pkg::req_item_t item;
        item.req_type      = kind;
        item.vector_number = vec;
        pending_reqs.push_back(item);
    endtask

    // Random requests; frees mostly target the allocatable range
    task automatic add_random_reqs(input int n, input int alloc_pct);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < alloc_pct)
                add_req(ivau_pkg::REQ_ALLOC, 8'($urandom_range(0, 255)));
            else if ($urandom_range(0, 4) != 0)
                add_req(ivau_pkg::REQ_FREE, 8'($urandom_range(ivau_pkg::FIRST_ALLOC, 255)));
            else
                add_req(ivau_pkg::REQ_FREE, 8'($urandom_range(0, 255)));
        end
    endtask

    // Driver: offers pending requests, predicts each accepted one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_if.valid <= 1'b0;
            req_if.data  <= '0;
            gap_cnt      <= 0;
            sent_cnt     <= 0;
            for (int v = 0; v < NUM_VECTORS; v++)
                vec_in_use[v] = (v < ivau_pkg::RSV_LOW) || (v == ivau_pkg::RSV_VEC_A) ||
                                (v == ivau_pkg::RSV_VEC_B);
        end
        else
        begin
            if (req_if.valid && req_if.ready)
            begin
                expected_grants.push_back(predict_grant(req_if.data));
                sent_cnt <= sent_cnt + 1;
            end

            if (req_if.valid && !req_if.ready)
            begin
                // Hold the item until it is taken
            end
            else if (gap_cnt > 0)
            begin
                req_if.valid <= 1'b0;
                gap_cnt      <= gap_cnt - 1;
            end
            else if (pending_reqs.size() > 0)
            begin
                req_if.valid <= 1'b1;
                req_if.data  <= pending_reqs.pop_front();
                gap_cnt      <= draw_idle(sent_cnt);
            end
            else
            begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each response against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin : rsp_monitor
        int                  next_stall;
        ivau_pkg::rsp_item_t want;
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            stall_cnt    <= 0;
            rcv_cnt      <= 0;
            mismatch_cnt <= 0;
        end
        else
        begin
            next_stall = stall_cnt;
            if (rsp_if.valid && rsp_if.ready)
            begin
                rcv_cnt    <= rcv_cnt + 1;
                next_stall = draw_idle(rcv_cnt);
                if (expected_grants.size() == 0)
                begin
                    if (mismatch_cnt < MAX_REPORTS)
                        $display("ERROR: response %0d arrived with nothing predicted: vec %0d ok %0b",
                                 rcv_cnt, rsp_if.data.granted_vector, rsp_if.data.success);
                    mismatch_cnt <= mismatch_cnt + 1;
                end
                else
                begin
                    want = expected_grants.pop_front();
                    if (rsp_if.data.granted_vector !== want.granted_vector ||
                        rsp_if.data.success !== want.success)
                    begin
                        if (mismatch_cnt < MAX_REPORTS)
                            $display("ERROR: response %0d: expected vec %0d ok %0b, got vec %0d ok %0b",
                                     rcv_cnt, want.granted_vector, want.success,
                                     rsp_if.data.granted_vector, rsp_if.data.success);
                        mismatch_cnt <= mismatch_cnt + 1;
                    end
                end
            end

            if (hold_rsp)
            begin
                rsp_if.ready <= 1'b0;
                stall_cnt    <= next_stall;
            end
            else if (next_stall > 0)
            begin
                rsp_if.ready <= 1'b0;
                stall_cnt    <= next_stall - 1;
            end
            else
            begin
                rsp_if.ready <= 1'b1;
                stall_cnt    <= 0;
            end
        end
    end

    // Long receiver hold-off so the block backs up into its request side
    initial
    begin
        hold_rsp = 1'b0;
        wait (rcv_cnt >= 150);
        @(posedge clk);
        hold_rsp <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rsp <= 1'b0;
    end

    // Hard limit on the run
    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Stimulus and end of run
    initial
    begin
        // Directed: first grants, reuse of a freed vector, reserved and edge frees
        add_req(ivau_pkg::REQ_ALLOC, 8'd0);
        add_req(ivau_pkg::REQ_ALLOC, 8'd0);
        add_req(ivau_pkg::REQ_FREE, 8'd48);
        add_req(ivau_pkg::REQ_ALLOC, 8'd0);
        add_req(ivau_pkg::REQ_FREE, 8'h40);
        add_req(ivau_pkg::REQ_FREE, 8'h21);
        add_req(ivau_pkg::REQ_FREE, 8'd0);
        add_req(ivau_pkg::REQ_FREE, 8'd255);
        add_req(ivau_pkg::REQ_ALLOC, 8'd255);
        add_req(ivau_pkg::REQ_FREE, 8'd50);
        add_req(ivau_pkg::REQ_FREE, 8'd50);
        add_req(ivau_pkg::REQ_ALLOC, 8'hAA);
        add_req(ivau_pkg::REQ_FREE, 8'd31);
        add_req(ivau_pkg::REQ_FREE, 8'd32);
        add_req(ivau_pkg::REQ_FREE, 8'd47);
        add_req(ivau_pkg::REQ_ALLOC, 8'h55);
        add_req(ivau_pkg::REQ_FREE, 8'd254);
        add_req(ivau_pkg::REQ_ALLOC, 8'd1);

        // Fill the map past exhaustion, churn with frees, then refill
        add_random_reqs(260, 95);
        add_random_reqs(200, 30);
        add_random_reqs(140, 70);
        total_reqs = pending_reqs.size();

        wait (rst_n === 1'b1);
        wait (sent_cnt == total_reqs);
        while (expected_grants.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_cnt == 0 && expected_grants.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
